// ----- hw/rtl/adaptive_proposal_scale_top_defines.svh -----
// Assertion macros shared by the adaptive proposal scale RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ADAPTIVE_PROPOSAL_SCALE_TOP_DEFINES_SVH
`define ADAPTIVE_PROPOSAL_SCALE_TOP_DEFINES_SVH

// condition holds at every clock edge out of reset
`define APS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define APS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define APS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/aps_pkg.sv -----
// Shared constants, codes and control structs for the adaptive proposal scale block.
// No dependencies; imported by the interfaces, the multiplier, the divider, the top and the testbench.
package aps_pkg;

   localparam int unsigned RATE_W  = 16;
   localparam int unsigned EMA_W   = 17;
   localparam int unsigned SCALE_W = 24;

   // serial multiplier: multiplicand x multiplier, one multiplier bit per cycle
   localparam int unsigned MUL_A_W   = 24;
   localparam int unsigned MUL_B_W   = 17;
   localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W);

   // restoring divider: one quotient bit per cycle
   localparam int unsigned DIV_Q_W   = 24;
   localparam int unsigned DIV_R_W   = 17;
   localparam int unsigned DIV_CNT_W = 5;

   localparam int unsigned THR_W = 37;

   localparam logic [EMA_W-1:0]   Q16_ONE      = 17'd65536;
   localparam logic [SCALE_W-1:0] SCALE_RESET  = 24'd1048576;
   localparam logic [SCALE_W-1:0] SCALE_MIN    = 24'd105;
   localparam logic [SCALE_W-1:0] SCALE_MAX    = 24'd10485760;
   localparam logic [EMA_W-1:0]   EMA_RESET    = 17'd15073;
   localparam logic [EMA_W-1:0]   WEIGHT_RESET = 17'd131;
   localparam logic [RATE_W-1:0]  TARGET_RESET = 16'd15335;
   localparam logic [RATE_W-1:0]  LRATE_RESET  = 16'd3277;
   localparam logic [RATE_W-1:0]  PERIOD_RESET = 16'd1000;

   localparam logic [17:0] WEIGHT_NUM = 18'd131072;
   localparam logic [DIV_CNT_W-1:0] WEIGHT_ITERS = 5'd17;
   localparam logic [DIV_CNT_W-1:0] SCALE_ITERS  = 5'd24;

   // thresholds: 0.952381 and 1.05 of target, compared exactly
   localparam logic [19:0] BELOW_EMA_K = 20'd1000000;
   localparam logic [19:0] BELOW_TGT_K = 20'd952381;
   localparam logic [6:0]  ABOVE_EMA_K = 7'd100;
   localparam logic [6:0]  ABOVE_TGT_K = 7'd105;

   typedef enum logic [1:0] {
      CSR_TARGET = 2'd0,
      CSR_LRATE  = 2'd1,
      CSR_PERIOD = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_ACCEPT = 1'b0,
      OP_UPDATE = 1'b1
   } op_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] iters;
      logic [DIV_R_W-1:0]   rem;
      logic [DIV_Q_W-1:0]   num;
      logic [DIV_R_W-1:0]   divisor;
   } div_req_type;

endpackage

// ----- hw/rtl/aps_if.sv -----
// Handshake channels of the adaptive proposal scale block: event words in, result words out.
// Depends on aps_pkg for field widths.
interface aps_req_if import aps_pkg::*;;
   logic              valid;
   logic              ready;
   logic              op;
   logic              accepted;
   logic [RATE_W-1:0] random_fraction;

   modport source (output valid, output op, output accepted, output random_fraction,
                   input ready);
   modport sink   (input valid, input op, input accepted, input random_fraction,
                   output ready);
endinterface

interface aps_rsp_if import aps_pkg::*;;
   logic               valid;
   logic               ready;
   logic [SCALE_W-1:0] scale;
   logic [EMA_W-1:0]   acceptance_average;

   modport source (output valid, output scale, output acceptance_average, input ready);
   modport sink   (input valid, input scale, input acceptance_average, output ready);
endinterface

// ----- hw/rtl/aps_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on aps_pkg for widths and the request struct.
module aps_mul import aps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  mul_req_type        req,
   output logic               done,
   output logic [MUL_P_W-1:0] product
);

   logic [MUL_A_W-1:0]   a_ff;
   logic [MUL_A_W-1:0]   hi_ff;
   logic [MUL_B_W-1:0]   lo_ff;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [MUL_A_W:0]     sum_in;

   // partial product enters the high half, the low half shifts right
   assign sum_in = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            a_ff    <= req.a;
            hi_ff   <= '0;
            lo_ff   <= req.b;
            cnt_ff  <= MUL_CNT_W'(MUL_B_W - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            hi_ff <= sum_in[MUL_A_W:1];
            lo_ff <= {sum_in[0], lo_ff[MUL_B_W-1:1]};
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

// ----- hw/rtl/aps_div.sv -----
// Restoring divider, one quotient bit per cycle; numerator bits shift in from a register.
// Depends on aps_pkg for widths and the request struct.
module aps_div import aps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  div_req_type        req,
   output logic               done,
   output logic [DIV_Q_W-1:0] quotient
);

   logic [DIV_R_W-1:0]   rem_ff;
   logic [DIV_Q_W-1:0]   q_ff;
   logic [DIV_R_W-1:0]   dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_R_W:0]     shifted_in;
   logic [DIV_R_W+1:0]   trial_in;
   logic                 fits_in;
   logic [DIV_R_W-1:0]   rem_in;

   assign shifted_in = {rem_ff, q_ff[DIV_Q_W-1]};
   assign trial_in   = {1'b0, shifted_in} - {2'b00, dvs_ff};
   assign fits_in    = ~trial_in[DIV_R_W+1];
   assign rem_in     = fits_in ? trial_in[DIV_R_W-1:0] : shifted_in[DIV_R_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            rem_ff  <= req.rem;
            q_ff    <= req.num;
            dvs_ff  <= req.divisor;
            cnt_ff  <= req.iters - 1'b1;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            q_ff   <= {q_ff[DIV_Q_W-2:0], fits_in};
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ----- hw/rtl/adaptive_proposal_scale_top.sv -----
// Adaptive proposal scale: sequencer, state registers and threshold compare.
// Depends on aps_pkg, aps_if, aps_mul, aps_div and the assertion macro header.
//
//  channel  dir  handshake      word
//  req_ch   in   valid/ready    op, accepted, random_fraction
//  rsp_ch   out  valid/ready    scale, acceptance_average
//  csr_*    in   write enable   index, 16-bit data
//
// Accept event: serial multiply of the weight into the average step.
// Update event: learn-rate multiply, then a multiply (increase), a divide (decrease)
// or no scale step while the average lies between the thresholds.
// A period write runs a divide for the weight; req_ch waits meanwhile.
// The result register frees the input side: the next word is taken while a result
// waits, and a finished word holds until the result register is free.
// Reset is synchronous and restores the register and state defaults.
`include "adaptive_proposal_scale_top_defines.svh"

module adaptive_proposal_scale_top import aps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   aps_req_if.sink           req_ch,
   aps_rsp_if.source         rsp_ch,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [RATE_W-1:0] csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WEIGHT,
      ST_EMA,
      ST_LEARN,
      ST_DIV,
      ST_SCL,
      ST_FIN
   } state_type;

   state_type          state_ff;
   logic [RATE_W-1:0]  target_ff;
   logic [RATE_W-1:0]  lrate_ff;
   logic [RATE_W-1:0]  period_ff;
   logic [EMA_W-1:0]   ema_ff;
   logic [EMA_W-1:0]   weight_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic               wpend_ff;
   logic               acc_ff;
   logic               thr_run_ff;
   logic [1:0]         thr_step_ff;
   logic [THR_W-1:0]   lhs_ff;
   logic               below_ff;
   logic               above_ff;
   logic               rsp_valid_ff;
   logic [SCALE_W-1:0] rsp_scale_ff;
   logic [EMA_W-1:0]   rsp_avg_ff;

   mul_req_type        mul_req;
   logic               mul_done;
   logic [MUL_P_W-1:0] mul_product;
   div_req_type        div_req;
   logic               div_done;
   logic [DIV_Q_W-1:0] div_quotient;

   logic               req_fire;
   logic               rsp_load_w;
   logic [EMA_W-1:0]   learn_w;
   logic [EMA_W-1:0]   ema_step_w;
   logic [EMA_W-1:0]   period_p1_w;
   logic [17:0]        weight_num_w;
   logic [SCALE_W:0]   scale_up_w;

   aps_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .done    (mul_done),
      .product (mul_product)
   );

   aps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_ch.ready = (state_ff == ST_IDLE) && !wpend_ff;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_load_w   = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ch.ready);

   // learn rate is 1.0 plus a product that stays below 1.0, so the top bit is constant
   assign learn_w    = {1'b1, mul_product[31:16]};
   assign ema_step_w = mul_product[32:16];
   assign scale_up_w = mul_product[40:16];

   // weight = 2.0/p in Q16 rounded half up, p = period + 1, a zero period counting as one
   assign period_p1_w  = ((period_ff == '0) ? 17'd1 : {1'b0, period_ff}) + 17'd1;
   assign weight_num_w = WEIGHT_NUM + {2'b00, period_p1_w[EMA_W-1:1]};

   always_comb begin
      mul_req = '0;
      div_req = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (wpend_ff) begin
               div_req.start   = 1'b1;
               div_req.iters   = WEIGHT_ITERS;
               div_req.rem     = {{(DIV_R_W-1){1'b0}}, weight_num_w[17]};
               div_req.num     = {weight_num_w[16:0], {(DIV_Q_W-17){1'b0}}};
               div_req.divisor = period_p1_w;
            end else if (req_fire) begin
               mul_req.start = 1'b1;
               if (op_type'(req_ch.op) == OP_UPDATE) begin
                  mul_req.a = MUL_A_W'(lrate_ff);
                  mul_req.b = MUL_B_W'(req_ch.random_fraction);
               end else begin
                  mul_req.a = MUL_A_W'(req_ch.accepted ? (Q16_ONE - ema_ff) : ema_ff);
                  mul_req.b = weight_ff;
               end
            end
         end
         ST_LEARN: begin
            if (mul_done) begin
               if (below_ff) begin
                  // scale << 16 over learn; the quotient fits 24 bits, so start part way
                  div_req.start   = 1'b1;
                  div_req.iters   = SCALE_ITERS;
                  div_req.rem     = {1'b0, scale_ff[SCALE_W-1:8]};
                  div_req.num     = {scale_ff[7:0], 16'b0};
                  div_req.divisor = learn_w;
               end else if (above_ff) begin
                  mul_req.start = 1'b1;
                  mul_req.a     = scale_ff;
                  mul_req.b     = learn_w;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= TARGET_RESET;
         lrate_ff     <= LRATE_RESET;
         period_ff    <= PERIOD_RESET;
         ema_ff       <= EMA_RESET;
         weight_ff    <= WEIGHT_RESET;
         scale_ff     <= SCALE_RESET;
         wpend_ff     <= 1'b0;
         acc_ff       <= 1'b0;
         thr_run_ff   <= 1'b0;
         thr_step_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load_w) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // thresholds, one constant product per step, done well inside the learn multiply
         if (thr_run_ff) begin
            thr_step_ff <= thr_step_ff + 1'b1;
            unique case (thr_step_ff)
               2'd0: lhs_ff   <= THR_W'(ema_ff) * THR_W'(BELOW_EMA_K);
               2'd1: below_ff <= lhs_ff < (THR_W'(target_ff) * THR_W'(BELOW_TGT_K));
               2'd2: lhs_ff   <= THR_W'(ema_ff) * THR_W'(ABOVE_EMA_K);
               default: begin
                  above_ff   <= lhs_ff > (THR_W'(target_ff) * THR_W'(ABOVE_TGT_K));
                  thr_run_ff <= 1'b0;
               end
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (wpend_ff) begin
                  state_ff <= ST_WEIGHT;
               end else if (req_fire) begin
                  acc_ff <= req_ch.accepted;
                  if (op_type'(req_ch.op) == OP_UPDATE) begin
                     thr_run_ff  <= 1'b1;
                     thr_step_ff <= '0;
                     state_ff    <= ST_LEARN;
                  end else begin
                     state_ff <= ST_EMA;
                  end
               end
            end
            ST_WEIGHT: begin
               if (div_done) begin
                  weight_ff <= div_quotient[EMA_W-1:0];
                  state_ff  <= ST_IDLE;
               end
            end
            ST_EMA: begin
               if (mul_done) begin
                  ema_ff   <= acc_ff ? (ema_ff + ema_step_w) : (ema_ff - ema_step_w);
                  state_ff <= ST_FIN;
               end
            end
            ST_LEARN: begin
               if (mul_done) begin
                  priority if (below_ff) state_ff <= ST_DIV;
                  else if (above_ff)     state_ff <= ST_SCL;
                  else                   state_ff <= ST_FIN;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  scale_ff <= (div_quotient < SCALE_MIN) ? SCALE_MIN : div_quotient;
                  state_ff <= ST_FIN;
               end
            end
            ST_SCL: begin
               if (mul_done) begin
                  scale_ff <= (scale_up_w > {1'b0, SCALE_MAX}) ? SCALE_MAX
                                                               : scale_up_w[SCALE_W-1:0];
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (rsp_load_w) begin
                  rsp_scale_ff <= scale_ff;
                  rsp_avg_ff   <= ema_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // a period write arms the weight divide, which the idle step then starts
         if (csr_write_en && (csr_index_type'(csr_index) == CSR_PERIOD)) begin
            wpend_ff <= 1'b1;
         end else if (state_ff == ST_IDLE) begin
            wpend_ff <= 1'b0;
         end

         if (csr_write_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_TARGET: target_ff <= csr_write_data;
               CSR_LRATE:  lrate_ff  <= csr_write_data;
               CSR_PERIOD: period_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.scale              = rsp_scale_ff;
   assign rsp_ch.acceptance_average = rsp_avg_ff;

   `APS_ASSERT_ALWAYS(a_scale_range, clock, reset,
      (scale_ff >= SCALE_MIN) && (scale_ff <= SCALE_MAX), "scale left its saturation range")
   `APS_ASSERT_ALWAYS(a_ema_range, clock, reset,
      ema_ff <= Q16_ONE, "acceptance average above 1.0")
   `APS_ASSERT_NEXT(a_accept_leaves_idle, clock, reset,
      req_fire, state_ff != ST_IDLE, "accepted word did not start work")
   `APS_ASSERT_IMPLY(a_mul_done_owner, clock, reset, mul_done,
      (state_ff == ST_EMA) || (state_ff == ST_LEARN) || (state_ff == ST_SCL),
      "multiplier finished with no step waiting")
   `APS_ASSERT_IMPLY(a_div_done_owner, clock, reset, div_done,
      (state_ff == ST_WEIGHT) || (state_ff == ST_DIV), "divider finished with no step waiting")

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for adaptive_proposal_scale_top: event words in, scale and
// average words out, with a scoreboard that predicts both from its own state.
// Depends on aps_pkg and the aps_req_if / aps_rsp_if interfaces of the RTL.
`timescale 1ns / 100ps

module testbench;
   import aps_pkg::*;

   localparam logic [1:0] CSR_SPARE  = 2'd3;  // beyond the register list, write is dropped
   localparam int         IDLE_LIMIT = 4000;
   localparam int         DRAIN_WAIT = 64;

   class scale_scoreboard;
      typedef struct {
         logic [SCALE_W-1:0] scale;
         logic [EMA_W-1:0]   average;
      } scale_word_type;

      logic [RATE_W-1:0]  target;
      logic [RATE_W-1:0]  lrate;
      logic [EMA_W-1:0]   weight;
      logic [EMA_W-1:0]   ema;
      logic [SCALE_W-1:0] scale;
      scale_word_type     expected_q[$];
      int                 failures;

      function new();
         target   = TARGET_RESET;
         lrate    = LRATE_RESET;
         weight   = WEIGHT_RESET;
         ema      = EMA_RESET;
         scale    = SCALE_RESET;
         failures = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void write_register(logic [1:0] index, logic [RATE_W-1:0] data);
         logic [63:0] p;
         logic [63:0] w;
         case (index)
            CSR_TARGET: target = data;
            CSR_LRATE:  lrate  = data;
            CSR_PERIOD: begin
               // weight = 2/(period+1), rounded half up; a zero period counts as one
               p = 64'(data == 0 ? 16'd1 : data) + 64'd1;
               w = (64'(WEIGHT_NUM) + p / 2) / p;
               if (w > 64'(Q16_ONE))
                  w = 64'(Q16_ONE);
               weight = w[EMA_W-1:0];
            end
            default: ;
         endcase
      endfunction

      function void note_event(op_type op, logic acc, logic [RATE_W-1:0] rnd);
         logic [63:0] e;
         logic [63:0] w;
         logic [63:0] t;
         logic [63:0] s;
         logic [63:0] learn;
         scale_word_type word;
         e = 64'(ema);
         w = 64'(weight);
         t = 64'(target);
         s = 64'(scale);
         if (op == OP_ACCEPT) begin
            if (acc)
               e = e + (((64'(Q16_ONE) - e) * w) >> 16);
            else
               e = e - ((e * w) >> 16);
            if (e > 64'(Q16_ONE))
               e = 64'(Q16_ONE);
            ema = e[EMA_W-1:0];
         end else begin
            learn = 64'(Q16_ONE) + ((64'(rnd) * 64'(lrate)) >> 16);
            if (e * 64'd1000000 < 64'd952381 * t) begin
               s = (s << 16) / learn;
               if (s < 64'(SCALE_MIN))
                  s = 64'(SCALE_MIN);
            end else if (e * 64'd100 > 64'd105 * t) begin
               s = (s * learn) >> 16;
               if (s > 64'(SCALE_MAX))
                  s = 64'(SCALE_MAX);
            end
            scale = s[SCALE_W-1:0];
         end
         word.scale   = scale;
         word.average = ema;
         expected_q.push_back(word);
      endfunction

      function void check_result(logic [SCALE_W-1:0] s, logic [EMA_W-1:0] a);
         scale_word_type word;
         if (expected_q.size() == 0) begin
            $error("result word with nothing expected: scale %0d average %0d", s, a);
            failures++;
            return;
         end
         word = expected_q.pop_front();
         if (s !== word.scale) begin
            $error("scale: expected %0d, actual %0d", word.scale, s);
            failures++;
         end
         if (a !== word.average) begin
            $error("acceptance_average: expected %0d, actual %0d", word.average, a);
            failures++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_write_en;
   logic [1:0]        csr_index;
   logic [RATE_W-1:0] csr_write_data;

   aps_req_if req_ch();
   aps_rsp_if rsp_ch();

   adaptive_proposal_scale_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   scale_scoreboard sb;
   int  idle_cycles = 0;
   int  stall_left  = 0;
   bit  stalls_on   = 0;
   bit  gaps_on     = 1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: random ready stalls while enabled
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (stalls_on && $urandom_range(0, 3) == 0)
            stall_left = $urandom_range(1, 40);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.scale, rsp_ch.acceptance_average);
         if (req_ch.valid && req_ch.ready)
            sb.note_event(op_type'(req_ch.op), req_ch.accepted, req_ch.random_fraction);
         if (csr_write_en)
            sb.write_register(csr_index, csr_write_data);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready) || csr_write_en)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(op_type op, logic acc, logic [RATE_W-1:0] rnd);
      req_ch.valid           <= 1'b1;
      req_ch.op              <= op;
      req_ch.accepted        <= acc;
      req_ch.random_fraction <= rnd;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [RATE_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // drop valid and wait for every outstanding result
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [RATE_W-1:0] pick_rate();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return RATE_W'($urandom);
      endcase
   endfunction

   function automatic logic [RATE_W-1:0] pick_period();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return RATE_W'($urandom);
         default: return RATE_W'($urandom_range(1, 12));
      endcase
   endfunction

   task automatic run_random_phase(int n_words, int update_pct, int accept_pct);
      int          burst_left;
      op_type      op;
      logic        acc;
      logic [15:0] rnd;
      burst_left = 0;
      for (int i = 0; i < n_words; i++) begin
         if (burst_left == 0) begin
            burst_left = gaps_on ? $urandom_range(1, 20) : n_words;
            if (gaps_on) begin
               req_ch.valid <= 1'b0;
               repeat ($urandom_range(1, 16)) @(negedge clock);
            end
         end
         op  = ($urandom_range(0, 99) < update_pct) ? OP_UPDATE : OP_ACCEPT;
         acc = (op == OP_ACCEPT) ? ($urandom_range(0, 99) < accept_pct) : 1'($urandom);
         case ($urandom_range(0, 7))
            0:       rnd = '0;
            1:       rnd = '1;
            default: rnd = 16'($urandom);
         endcase
         send_word(op, acc, rnd);
         burst_left--;
      end
      settle();
   endtask

   initial begin
      sb                     = new();
      clock                  = 1'b0;
      reset                  = 1'b1;
      csr_write_en           = 1'b0;
      csr_index              = '0;
      csr_write_data         = '0;
      req_ch.valid           = 1'b0;
      req_ch.op              = OP_ACCEPT;
      req_ch.accepted        = 1'b0;
      req_ch.random_fraction = '0;
      rsp_ch.ready           = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // reset defaults: average sits between the thresholds
      send_word(OP_ACCEPT, 1'b1, 16'h0000);
      send_word(OP_ACCEPT, 1'b0, 16'hFFFF);
      send_word(OP_UPDATE, 1'b1, 16'h0000);
      send_word(OP_UPDATE, 1'b0, 16'hFFFF);
      settle();

      // zero period gives full weight; drive the scale down onto its floor
      write_csr(CSR_TARGET, 16'hFFFF);
      write_csr(CSR_PERIOD, 16'h0000);
      write_csr(CSR_LRATE, 16'hFFFF);
      write_csr(CSR_SPARE, 16'hFFFF);
      send_word(OP_ACCEPT, 1'b0, 16'h1234);
      repeat (15) send_word(OP_UPDATE, 1'b1, 16'hFFFF);
      settle();

      // zero target, longest period, no learning
      write_csr(CSR_TARGET, 16'h0000);
      write_csr(CSR_PERIOD, 16'hFFFF);
      write_csr(CSR_LRATE, 16'h0000);
      send_word(OP_UPDATE, 1'b0, 16'hFFFF);
      send_word(OP_ACCEPT, 1'b1, 16'h0000);
      send_word(OP_UPDATE, 1'b1, 16'hFFFF);
      settle();

      for (int phase = 0; phase < 10; phase++) begin
         write_csr(CSR_TARGET, pick_rate());
         write_csr(CSR_LRATE, pick_rate());
         write_csr(CSR_PERIOD, pick_period());
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_SPARE, 16'($urandom));
         stalls_on = (phase % 3) != 0;
         gaps_on   = (phase % 4) != 1;
         run_random_phase(55, $urandom_range(25, 60), $urandom_range(0, 100));
      end

      stalls_on = 0;
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/aps_pkg.sv
hw/rtl/aps_if.sv
hw/rtl/aps_mul.sv
hw/rtl/aps_div.sv
hw/rtl/adaptive_proposal_scale_top.sv
test/testbench.sv
